>>> rtl/core/tcpsyn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsyn_pkg
// Shared types and constants of the TCP SYN header builder: register codes,
// the fixed header words and the constant part of the TCP checksum.
// ----------------------------------------------------------------------------
package tcpsyn_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned HALF_W     = 16;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned WORD_COUNT = 10;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_COUNT - 1);

	// Configuration register codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_ADDRESS = 2'd0,
		REG_SOURCE_PORT    = 2'd1,
		REG_TARGET_PORT    = 2'd2
	} cfg_reg_t;

	// Configuration register contents
	typedef struct packed {
		logic [WORD_W-1:0] source_address;
		logic [HALF_W-1:0] source_port_value;
		logic [HALF_W-1:0] target_port;
	} cfg_t;

	// Fixed header words
	localparam logic [WORD_W-1:0] IP_WORD0    = 32'h4500_0028;
	localparam logic [WORD_W-1:0] IP_WORD1    = 32'h0000_0000;
	localparam logic [WORD_W-1:0] IP_WORD2    = 32'hFF06_0000;
	localparam logic [WORD_W-1:0] TCP_SEQ     = 32'd30000;
	localparam logic [WORD_W-1:0] TCP_ACK     = 32'h0000_0000;
	localparam logic [WORD_W-1:0] TCP_FLAGWIN = 32'h5002_2744;

	localparam logic [HALF_W-1:0] PROTO_TCP = 16'h0006;
	localparam logic [HALF_W-1:0] TCP_LEN   = 16'd20;

	// Sum width: six 16-bit operands plus a constant below 2^16 fit in 19 bits
	localparam int unsigned SUM_W = 19;

	// Constant part of the pseudo-header and TCP header sum
	localparam logic [SUM_W-1:0] CSUM_CONST =
		SUM_W'(PROTO_TCP) + SUM_W'(TCP_LEN) +
		SUM_W'(TCP_SEQ[31:16]) + SUM_W'(TCP_SEQ[15:0]) +
		SUM_W'(TCP_ACK[31:16]) + SUM_W'(TCP_ACK[15:0]) +
		SUM_W'(TCP_FLAGWIN[31:16]) + SUM_W'(TCP_FLAGWIN[15:0]);

endpackage

>>> rtl/core/tcpsyn_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsyn_cfg
// Configuration register file: source address and the two TCP ports.
// ----------------------------------------------------------------------------
module tcpsyn_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [tcpsyn_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [tcpsyn_pkg::WORD_W-1:0]      wr_data,
	output tcpsyn_pkg::cfg_t                   cfg
);

	tcpsyn_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				tcpsyn_pkg::REG_SOURCE_ADDRESS: begin
					cfg_q.source_address <= wr_data;
				end
				tcpsyn_pkg::REG_SOURCE_PORT: begin
					cfg_q.source_port_value <= wr_data[tcpsyn_pkg::HALF_W-1:0];
				end
				tcpsyn_pkg::REG_TARGET_PORT: begin
					cfg_q.target_port <= wr_data[tcpsyn_pkg::HALF_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/tcpsyn_csum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsyn_csum
// TCP checksum: ones-complement sum over pseudo-header and TCP header,
// folded to 16 bits and complemented.
// ----------------------------------------------------------------------------
module tcpsyn_csum (
	input  tcpsyn_pkg::cfg_t                  cfg,
	input  logic [tcpsyn_pkg::WORD_W-1:0]     dest_address,
	output logic [tcpsyn_pkg::HALF_W-1:0]     csum
);

	localparam int unsigned SW = tcpsyn_pkg::SUM_W;
	localparam int unsigned HW = tcpsyn_pkg::HALF_W;

	logic [SW-1:0] sum;
	logic [HW:0]   fold1;
	logic [HW:0]   fold2;

	// Add the variable halves onto the constant part
	assign sum = tcpsyn_pkg::CSUM_CONST +
		SW'(cfg.source_address[31:16]) + SW'(cfg.source_address[15:0]) +
		SW'(dest_address[31:16]) + SW'(dest_address[15:0]) +
		SW'(cfg.source_port_value) + SW'(cfg.target_port);

	// Fold the carries back in twice, then complement
	assign fold1 = (HW+1)'(sum[HW-1:0]) + (HW+1)'(sum[SW-1:HW]);
	assign fold2 = (HW+1)'(fold1[HW-1:0]) + (HW+1)'(fold1[HW]);
	assign csum  = ~fold2[HW-1:0];

endmodule

>>> rtl/core/tcp_syn_header_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_header_builder_unit
// Builds the 40-byte IPv4+TCP SYN probe header for one destination address
// and sends it as ten big-endian 32-bit words, the last one marked.
//
//   channel | signals                                      | flow
//   --------+----------------------------------------------+------------------
//   request | start, busy, dest_address                    | in, start/busy
//   result  | word_valid, header_word, word_index, last_word | out, strobe only
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in, valid/ready
//
// Each request produces ten words on consecutive cycles, one word per cycle
// from the output register, through the holding register and the word
// sequencer. One request waits in the holding register while the previous
// one streams, so back-to-back requests leave no gap on the output. busy is
// high while that register is full and the sequencer is active and not on
// its last word. Reset clears the configuration to zero and drops any
// request in flight. The receiver cannot stall.
// ----------------------------------------------------------------------------
module tcp_syn_header_builder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// request
	input  logic                               start,
	output logic                               busy,
	input  logic [tcpsyn_pkg::WORD_W-1:0]      dest_address,
	// result
	output logic                               word_valid,
	output logic [tcpsyn_pkg::WORD_W-1:0]      header_word,
	output logic [tcpsyn_pkg::IDX_W-1:0]       word_index,
	output logic                               last_word,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tcpsyn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcpsyn_pkg::WORD_W-1:0]      cfg_data
);

	localparam int unsigned IW = tcpsyn_pkg::IDX_W;

	tcpsyn_pkg::cfg_t cfg;

	logic                         hold_vld_s1;
	logic [tcpsyn_pkg::WORD_W-1:0] hold_dest_s1;

	logic                         seq_active_s2;
	logic [IW-1:0]                seq_idx_s2;
	logic [tcpsyn_pkg::WORD_W-1:0] seq_dest_s2;
	logic [tcpsyn_pkg::HALF_W-1:0] seq_csum_s2;

	logic                         word_valid_q;
	logic [tcpsyn_pkg::WORD_W-1:0] header_word_q;
	logic [IW-1:0]                word_index_q;
	logic                         last_word_q;

	logic [tcpsyn_pkg::HALF_W-1:0] csum;
	logic                         seq_last;
	logic                         take;
	logic                         accept;
	logic [tcpsyn_pkg::WORD_W-1:0] word_mux;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	tcpsyn_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Checksum of the held request, registered on hand-off to the sequencer
	tcpsyn_csum u_csum (
		.cfg          (cfg),
		.dest_address (hold_dest_s1),
		.csum         (csum)
	);

	// Hand off when the sequencer is free or finishing its last word
	assign seq_last = (seq_idx_s2 == tcpsyn_pkg::LAST_IDX);
	assign take     = hold_vld_s1 && (!seq_active_s2 || seq_last);
	assign busy     = hold_vld_s1 && !take;
	assign accept   = start && !busy;

	// Holding register for one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_s1 <= 1'b0;
		end else if (accept) begin
			hold_vld_s1 <= 1'b1;
		end else if (take) begin
			hold_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_dest_s1 <= dest_address;
		end
	end

	// Word sequencer: load a request, then advance one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_active_s2 <= 1'b0;
			seq_idx_s2    <= '0;
		end else if (take) begin
			seq_active_s2 <= 1'b1;
			seq_idx_s2    <= '0;
		end else if (seq_active_s2) begin
			if (seq_last) begin
				seq_active_s2 <= 1'b0;
			end else begin
				seq_idx_s2 <= seq_idx_s2 + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			seq_dest_s2 <= hold_dest_s1;
			seq_csum_s2 <= csum;
		end
	end

	// Select the header word for the current position
	always_comb begin
		unique case (seq_idx_s2)
			4'd0:    word_mux = tcpsyn_pkg::IP_WORD0;
			4'd1:    word_mux = tcpsyn_pkg::IP_WORD1;
			4'd2:    word_mux = tcpsyn_pkg::IP_WORD2;
			4'd3:    word_mux = cfg.source_address;
			4'd4:    word_mux = seq_dest_s2;
			4'd5:    word_mux = {cfg.source_port_value, cfg.target_port};
			4'd6:    word_mux = tcpsyn_pkg::TCP_SEQ;
			4'd7:    word_mux = tcpsyn_pkg::TCP_ACK;
			4'd8:    word_mux = tcpsyn_pkg::TCP_FLAGWIN;
			4'd9:    word_mux = {seq_csum_s2, {tcpsyn_pkg::HALF_W{1'b0}}};
			default: word_mux = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= 1'b0;
		end else begin
			word_valid_q <= seq_active_s2;
		end
	end

	always_ff @(posedge clk) begin
		header_word_q <= word_mux;
		word_index_q  <= seq_idx_s2;
		last_word_q   <= seq_active_s2 && seq_last;
	end

	assign word_valid  = word_valid_q;
	assign header_word = header_word_q;
	assign word_index  = word_index_q;
	assign last_word   = last_word_q;

endmodule

>>> rtl/core/tcpsyn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpsyn_checker
// Port-level checks of the header builder: word ordering, header framing and
// the cause of busy.
// ----------------------------------------------------------------------------
module tcpsyn_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               word_valid,
	input logic [tcpsyn_pkg::WORD_W-1:0]      header_word,
	input logic [tcpsyn_pkg::IDX_W-1:0]       word_index,
	input logic                               last_word
);

	// Words of a header come back to back in increasing order
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && (word_index != tcpsyn_pkg::LAST_IDX) |=>
		word_valid && (word_index == $past(word_index) + tcpsyn_pkg::IDX_W'(1)))
		else $error("header word sequence broken");

	// A header never starts mid-stream without its earlier words
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && (word_index != '0) |-> $past(word_valid))
		else $error("header word without predecessor");

	// First word carries the fixed IP version/length word, last word is marked
	a_framing: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (last_word == (word_index == tcpsyn_pkg::LAST_IDX)) &&
		((word_index != '0) || (header_word == tcpsyn_pkg::IP_WORD0)))
		else $error("header framing wrong");

	// busy only rises after a request was taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted request");

endmodule

bind tcp_syn_header_builder_unit tcpsyn_checker u_tcpsyn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.word_valid  (word_valid),
	.header_word (header_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
